### sv/fnas_pkg.sv
// fnas_pkg: shared widths, register indexes and reset values for the
// four-neighbor average stencil core. no dependencies.
`default_nettype none

package fnas_pkg;

  localparam int PIX_W         = 16;   // pixel width, unsigned q0.16
  localparam int WREG_W        = 11;   // frame_width register width
  localparam int HREG_W        = 13;   // frame_height register width
  localparam int CFG_W         = 13;   // config write data, widest register
  localparam int CFG_IDX_W     = 1;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MIN_DIM       = 3;    // smallest usable width and height
  localparam int Q_DEPTH       = 2;    // output queue entries

  localparam logic [WREG_W-1:0] WIDTH_RST  = WREG_W'(1024);
  localparam logic [HREG_W-1:0] HEIGHT_RST = HREG_W'(1024);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH  = 1'b0,
    REG_FRAME_HEIGHT = 1'b1
  } cfg_reg_t;

endpackage

`default_nettype wire

### sv/fnas_ram.sv
// fnas_ram: generic single-write, dual-read ram with registered read data
// no dependencies; read returns old data on a same-cycle write
`default_nettype none

module fnas_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                                  clk,
  input  wire logic                                  we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                      wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr0,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr1,
  output logic      [WIDTH-1:0]                      rdata0,
  output logic      [WIDTH-1:0]                      rdata1
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata0 <= mem[raddr0];
    rdata1 <= mem[raddr1];
  end

endmodule

`default_nettype wire

### sv/four_neighbor_average_stencil_core.sv
// four_neighbor_average_stencil_core: one jacobi four-point smoothing pass
// over a raster pixel stream. depends on fnas_pkg and fnas_ram.
//
//   channel  dir  handshake                 payload
//   -------  ---  ------------------------  ---------------------------------
//   s_*      in   s_tvalid / s_tready       s_tdata = pixel_in, s_tuser = flush
//   m_*      out  m_tvalid / m_tready       m_tdata = pixel_out, m_tlast = frame_end
//   cfg_*    in   cfg_we (no wait)          cfg_index, cfg_data
//
// one request per clock, sustained while the output queue has room; the two line
// stores each give two reads a cycle and one write, so every pixel is a single
// read-modify-write pass; each result is queued when its request is taken
// reset clears the counters and the output queue; the line stores are not
// cleared and hold whatever was last written
// a two-entry output queue sits in front of m_*: s_tready only drops while
// both entries wait, so one stalled result never blocks the input
`default_nettype none

module four_neighbor_average_stencil_core #(
  parameter int MAX_WIDTH = fnas_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  // configuration write port
  input  wire logic                           cfg_we,
  input  wire logic [fnas_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [fnas_pkg::CFG_W-1:0]     cfg_data,
  // pixel input
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  input  wire logic [fnas_pkg::PIX_W-1:0]     s_tdata,   // [15:0] pixel_in
  input  wire logic                           s_tuser,   // [0] flush
  // smoothed output
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  output logic      [fnas_pkg::PIX_W-1:0]     m_tdata,   // [15:0] pixel_out
  output logic                                m_tlast    // frame_end
);

  localparam int PW     = fnas_pkg::PIX_W;
  localparam int WRW    = fnas_pkg::WREG_W;
  localparam int HRW    = fnas_pkg::HREG_W;
  // column index width, and a width wide enough for both the register and MAX_WIDTH
  localparam int CW     = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int EW_MAX = $clog2(MAX_WIDTH + 1);
  localparam int EW     = (EW_MAX > WRW) ? EW_MAX : WRW;
  localparam logic [EW-1:0] MAXW = EW'(MAX_WIDTH);
  localparam logic [EW-1:0] MINW = EW'(fnas_pkg::MIN_DIM);
  localparam logic [HRW-1:0] MINH = HRW'(fnas_pkg::MIN_DIM);
  localparam int QCW    = $clog2(fnas_pkg::Q_DEPTH + 1);
  localparam logic [QCW-1:0] Q_FULL = QCW'(fnas_pkg::Q_DEPTH);

  // clamp the programmed width into the usable range
  function automatic logic [EW-1:0] eff_width(input logic [WRW-1:0] fw);
    logic [EW-1:0] x;
    x = EW'(fw);
    if (x < MINW) begin
      x = MINW;
    end else if (x > MAXW) begin
      x = MAXW;
    end
    return x;
  endfunction

  // column index clamped to the last column of the row
  function automatic logic [CW-1:0] clamp_col(input logic [CW-1:0] col,
                                              input logic [EW-1:0] w);
    logic [EW-1:0] wm1;
    wm1 = w - EW'(1);
    return (EW'(col) > wm1) ? wm1[CW-1:0] : col;
  endfunction

  // config registers
  logic [WRW-1:0] frame_width, frame_width_next;
  logic [HRW-1:0] frame_height, frame_height_next;

  // raster position
  logic [CW-1:0]  column_count, column_count_next;
  logic [HRW-1:0] row_count, row_count_next;

  // current frame geometry
  logic [EW-1:0]  width_eff;
  logic [HRW-1:0] height_eff;
  logic [CW-1:0]  cur_col;
  logic           at_last_col;
  logic           drain;
  logic           interior;

  // handshake
  logic           accept;
  logic           pop;

  // line store ports
  logic           wr_en;
  logic [CW-1:0]  rd_col_src;
  logic [EW-1:0]  rd_width;
  logic [CW-1:0]  rd_col, rd_col_p1, rd_col_m1;
  logic [PW-1:0]  a_rd0, a_rd1, b_rd0, b_rd1;

  // read addresses and last write, kept for same-entry forwarding
  logic [CW-1:0]  rd_col_q, rd_col_p1_q, rd_col_m1_q;
  logic           fwd_we;
  logic [CW-1:0]  fwd_addr;
  logic [PW-1:0]  fwd_a, fwd_b;

  // neighbors of the pixel being smoothed
  logic [PW-1:0]  centre, right_px, up_px, left_px;
  logic [PW+1:0]  sum;
  logic [PW-1:0]  avg;

  // result of this request
  logic           res_valid;
  logic [PW-1:0]  res_pix;
  logic           res_last;

  // output queue
  logic [QCW-1:0] q_count;
  logic [PW-1:0]  q_pix  [fnas_pkg::Q_DEPTH];
  logic           q_last [fnas_pkg::Q_DEPTH];
  logic           push_slot;

  // config writes take effect at once
  always_comb begin
    frame_width_next  = frame_width;
    frame_height_next = frame_height;
    if (cfg_we && (cfg_index == fnas_pkg::REG_FRAME_WIDTH)) begin
      frame_width_next = cfg_data[WRW-1:0];
    end
    if (cfg_we && (cfg_index == fnas_pkg::REG_FRAME_HEIGHT)) begin
      frame_height_next = cfg_data[HRW-1:0];
    end
  end

  assign width_eff   = eff_width(frame_width);
  assign height_eff  = (frame_height < MINH) ? MINH : frame_height;
  assign cur_col     = clamp_col(column_count, width_eff);
  assign at_last_col = (EW'(cur_col) == (width_eff - EW'(1)));
  // once every input row is in, each request pushes out one pixel of the last row
  assign drain       = (row_count >= height_eff);
  // second input row emits the top border row unchanged
  assign interior    = (row_count != HRW'(1)) && (cur_col != '0) && !at_last_col;

  assign accept = s_tvalid && s_tready;

  // forward the write made on the same edge as the read
  assign centre   = (fwd_we && (fwd_addr == rd_col_q))    ? fwd_a : a_rd0;
  assign right_px = (fwd_we && (fwd_addr == rd_col_p1_q)) ? fwd_a : a_rd1;
  assign up_px    = (fwd_we && (fwd_addr == rd_col_q))    ? fwd_b : b_rd0;
  // row_two_above one column back already holds the left neighbor's row
  assign left_px  = (fwd_we && (fwd_addr == rd_col_m1_q)) ? fwd_b : b_rd1;

  assign sum = {2'b00, left_px} + {2'b00, right_px} + {2'b00, up_px} + {2'b00, s_tdata};
  assign avg = sum[PW+1:2];

  // counters, store write and result
  always_comb begin
    column_count_next = column_count;
    row_count_next    = row_count;
    wr_en             = 1'b0;
    res_valid         = 1'b0;
    res_pix           = centre;
    res_last          = 1'b0;
    if (accept) begin
      if (drain) begin
        res_valid = 1'b1;
        res_last  = at_last_col;
        if (at_last_col) begin
          column_count_next = '0;
          row_count_next    = '0;
        end else begin
          column_count_next = cur_col + CW'(1);
        end
      end else if (!s_tuser) begin
        wr_en     = 1'b1;
        // nothing comes out while the first row is loading
        res_valid = (row_count != '0);
        res_pix   = interior ? avg : centre;
        if (at_last_col) begin
          column_count_next = '0;
          row_count_next    = row_count + HRW'(1);
        end else begin
          column_count_next = cur_col + CW'(1);
        end
      end
    end
  end

  // read ahead for the position the next request will see
  assign rd_col_src = rst ? '0 : column_count_next;
  assign rd_width   = eff_width(rst ? fnas_pkg::WIDTH_RST : frame_width_next);
  assign rd_col     = clamp_col(rd_col_src, rd_width);
  assign rd_col_p1  = rd_col + CW'(1);
  assign rd_col_m1  = rd_col - CW'(1);

  // row r-1, then pixel moves in
  fnas_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_WIDTH)
  ) u_row_above (
    .clk    (clk),
    .we     (wr_en),
    .waddr  (cur_col),
    .wdata  (s_tdata),
    .raddr0 (rd_col),
    .raddr1 (rd_col_p1),
    .rdata0 (a_rd0),
    .rdata1 (a_rd1)
  );

  // row r-2, takes the old row r-1 entry
  fnas_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_WIDTH)
  ) u_row_two_above (
    .clk    (clk),
    .we     (wr_en),
    .waddr  (cur_col),
    .wdata  (centre),
    .raddr0 (rd_col),
    .raddr1 (rd_col_m1),
    .rdata0 (b_rd0),
    .rdata1 (b_rd1)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= fnas_pkg::WIDTH_RST;
      frame_height <= fnas_pkg::HEIGHT_RST;
      column_count <= '0;
      row_count    <= '0;
      fwd_we       <= 1'b0;
    end else begin
      frame_width  <= frame_width_next;
      frame_height <= frame_height_next;
      column_count <= column_count_next;
      row_count    <= row_count_next;
      fwd_we       <= wr_en;
    end
  end

  always_ff @(posedge clk) begin
    rd_col_q    <= rd_col;
    rd_col_p1_q <= rd_col_p1;
    rd_col_m1_q <= rd_col_m1;
    fwd_addr    <= cur_col;
    fwd_a       <= s_tdata;
    fwd_b       <= centre;
  end

  // output queue
  assign m_tvalid  = (q_count != '0);
  assign m_tdata   = q_pix[0];
  assign m_tlast   = q_last[0];
  assign s_tready  = (q_count != Q_FULL);
  assign pop       = m_tvalid && m_tready;
  assign push_slot = pop ? (q_count == Q_FULL) : (q_count != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      q_count <= '0;
    end else if (res_valid && !pop) begin
      q_count <= q_count + QCW'(1);
    end else if (!res_valid && pop) begin
      q_count <= q_count - QCW'(1);
    end
  end

  // head slot takes a new result when it lands there, else the shifted entry
  always_ff @(posedge clk) begin
    if (res_valid && !push_slot) begin
      q_pix[0]  <= res_pix;
      q_last[0] <= res_last;
    end else if (pop) begin
      q_pix[0]  <= q_pix[1];
      q_last[0] <= q_last[1];
    end
    if (res_valid && push_slot) begin
      q_pix[1]  <= res_pix;
      q_last[1] <= res_last;
    end
  end

endmodule

`default_nettype wire

### sv/fnas_checker.sv
// fnas_checker: port-level assertions for the stencil core, bound to the top
// depends on fnas_pkg and four_neighbor_average_stencil_core
`default_nettype none

module fnas_checker (
  input wire logic                       clk,
  input wire logic                       rst,
  input wire logic                       s_tready,
  input wire logic                       m_tvalid,
  input wire logic                       m_tready,
  input wire logic [fnas_pkg::PIX_W-1:0] m_tdata,
  input wire logic                       m_tlast
);

  // reset empties the output queue
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid right after reset");

  // an empty queue always takes a request
  a_empty_ready: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("input stalled with nothing waiting on the output");

  // a full queue stays full until a result leaves
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    (!s_tready && !m_tready) |=> !s_tready)
    else $error("queue lost an entry without a pop");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata) && $stable(m_tlast)))
    else $error("stalled output changed");

endmodule

bind four_neighbor_average_stencil_core fnas_checker u_fnas_checker (.*);

`default_nettype wire

### tb/tb_four_neighbor_average_stencil_core.sv
// tb_four_neighbor_average_stencil_core: self-checking testbench for the
// four-neighbor average stencil core, with its own stencil predictor and random
// idling on both stream sides. depends on fnas_pkg and the core.
`timescale 1ns / 1ps

module tb_four_neighbor_average_stencil_core;

  localparam int CYCLE_LIMIT = 3_000_000;  // far above the slowest legal run
  localparam int LONG_HOLD   = 400;        // receiver back-pressure stretch
  localparam int SETTLE_GAP  = 8;          // quiet cycles after the last result
  localparam int RANDOM_ITEMS = 300;

  // one accepted output pixel as the predictor sees it
  typedef struct packed {
    logic [fnas_pkg::PIX_W-1:0] pix;
    logic                       last;
  } smoothed_t;

  // travels with each request: typed expectation or predictor lookup
  typedef struct packed {
    logic                       typed;
    logic                       has_res;
    logic [fnas_pkg::PIX_W-1:0] pix;
    logic                       last;
  } req_note_t;

  typedef struct packed {
    logic [fnas_pkg::PIX_W-1:0] pix;
    logic                       flush;
    logic                       has_res;
    logic [fnas_pkg::PIX_W-1:0] exp_pix;
    logic                       exp_last;
  } directed_row_t;

  // two 3x3 frames: all-max first, then a cross pattern whose center is ignored
  localparam directed_row_t DIRECTED_ROWS [25] = '{
    // frame a, first row stored, nothing out
    '{16'hFFFF, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'hFFFF, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'hFFFF, 1'b0, 1'b0, 16'h0000, 1'b0},
    // flush before the drain phase does nothing
    '{16'h0000, 1'b1, 1'b0, 16'h0000, 1'b0},
    // second row releases the top border row
    '{16'hFFFF, 1'b0, 1'b1, 16'hFFFF, 1'b0},
    '{16'hFFFF, 1'b0, 1'b1, 16'hFFFF, 1'b0},
    '{16'hFFFF, 1'b0, 1'b1, 16'hFFFF, 1'b0},
    // third row, interior sum of four maxima still fits
    '{16'hFFFF, 1'b0, 1'b1, 16'hFFFF, 1'b0},
    '{16'hFFFF, 1'b0, 1'b1, 16'hFFFF, 1'b0},
    '{16'hFFFF, 1'b0, 1'b1, 16'hFFFF, 1'b0},
    // drain, a plain pixel counts like a flush there
    '{16'h0000, 1'b1, 1'b1, 16'hFFFF, 1'b0},
    '{16'h1234, 1'b0, 1'b1, 16'hFFFF, 1'b0},
    '{16'h0000, 1'b1, 1'b1, 16'hFFFF, 1'b1},
    // frame b
    '{16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'hFFFF, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'h0000, 1'b0, 1'b0, 16'h0000, 1'b0},
    '{16'hFFFF, 1'b0, 1'b1, 16'h0000, 1'b0},
    '{16'h1234, 1'b0, 1'b1, 16'hFFFF, 1'b0},
    '{16'hFFFF, 1'b0, 1'b1, 16'h0000, 1'b0},
    '{16'h0000, 1'b0, 1'b1, 16'hFFFF, 1'b0},
    '{16'hFFFF, 1'b0, 1'b1, 16'hFFFF, 1'b0},
    '{16'h0000, 1'b0, 1'b1, 16'hFFFF, 1'b0},
    '{16'h0000, 1'b1, 1'b1, 16'h0000, 1'b0},
    '{16'h0000, 1'b1, 1'b1, 16'hFFFF, 1'b0},
    '{16'h0000, 1'b1, 1'b1, 16'h0000, 1'b1}
  };

  logic                           clk = 1'b0;
  logic                           rst = 1'b1;
  logic                           cfg_we = 1'b0;
  logic [fnas_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [fnas_pkg::CFG_W-1:0]     cfg_data = '0;
  logic                           s_tvalid = 1'b0;
  logic                           s_tready;
  logic [fnas_pkg::PIX_W-1:0]     s_tdata = '0;
  logic                           s_tuser = 1'b0;
  logic                           m_tvalid;
  logic                           m_tready = 1'b0;
  logic [fnas_pkg::PIX_W-1:0]     m_tdata;
  logic                           m_tlast;

  four_neighbor_average_stencil_core uut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // [15:0] pixel_in
    .s_tuser  (s_tuser),    // [0] flush
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),    // [15:0] pixel_out
    .m_tlast  (m_tlast)     // frame_end
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // predictor state: line stores, raster position, register copies
  logic [fnas_pkg::PIX_W-1:0]  line_above     [fnas_pkg::MAX_WIDTH_DEF];
  logic [fnas_pkg::PIX_W-1:0]  line_two_above [fnas_pkg::MAX_WIDTH_DEF];
  int unsigned                 col_pos = 0;
  int unsigned                 row_pos = 0;
  logic [fnas_pkg::WREG_W-1:0] width_reg  = fnas_pkg::WIDTH_RST;
  logic [fnas_pkg::HREG_W-1:0] height_reg = fnas_pkg::HEIGHT_RST;

  smoothed_t expected_smoothed [$];
  req_note_t sent_notes [$];
  int        fail_count = 0;
  int        cycle_count = 0;

  // stimulus side view of the frame shape
  int frame_w_eff = fnas_pkg::MAX_WIDTH_DEF;
  int frame_h_eff = 1024;
  int items_sent  = 0;
  bit fast_phase  = 1'b0;   // short gaps only
  bit src_calm    = 1'b0;
  int hold_asked  = 0;

  function automatic int clamp_dim(input int v, input int hi);
    if (v < fnas_pkg::MIN_DIM) return fnas_pkg::MIN_DIM;
    if (v > hi) return hi;
    return v;
  endfunction

  // mostly back-to-back, some short gaps, a few long ones (none when quick)
  function automatic int pick_gap(input bit quick);
    int r;
    r = $urandom_range(0, 99);
    if (quick) return (r < 80) ? 0 : $urandom_range(1, 2);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [fnas_pkg::PIX_W-1:0] rand_pixel();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return fnas_pkg::PIX_W'($urandom);
    endcase
  endfunction

  // one stencil step per accepted request; returns 1 when a pixel comes out
  function automatic bit stencil_step(input logic [fnas_pkg::PIX_W-1:0] pix, input bit fl,
                                      output smoothed_t res);
    int unsigned                w, h, c, sum, in_row;
    logic [fnas_pkg::PIX_W-1:0] centre, smoothed;
    w = clamp_dim(int'(width_reg), fnas_pkg::MAX_WIDTH_DEF);
    h = clamp_dim(int'(height_reg), 1 << fnas_pkg::HREG_W);
    c = (col_pos >= w) ? w - 1 : col_pos;
    res = '0;
    // drain phase: emit the held last row, request content ignored
    if (row_pos >= h) begin
      res.pix  = line_above[c];
      res.last = (c + 1 >= w);
      if (res.last) begin
        col_pos = 0;
        row_pos = 0;
      end else begin
        col_pos = c + 1;
      end
      return 1'b1;
    end
    if (fl) return 1'b0;
    centre = line_above[c];
    // border rows and columns pass through
    if (row_pos <= 1 || c == 0 || c + 1 >= w) begin
      smoothed = centre;
    end else begin
      // left comes from the already shifted store
      sum = line_two_above[c-1] + line_above[c+1] + line_two_above[c] + pix;
      smoothed = fnas_pkg::PIX_W'(sum >> 2);
    end
    line_two_above[c] = centre;
    line_above[c]     = pix;
    if (c + 1 >= w) begin
      col_pos = 0;
      row_pos = (row_pos + 1) & ((1 << fnas_pkg::HREG_W) - 1);
      if (row_pos == 0) row_pos = h;
    end else begin
      col_pos = c + 1;
    end
    if (row_pos == 0 && col_pos == 0) return 1'b0;
    // nothing comes out while the first input row is stored
    in_row = (col_pos == 0) ? row_pos - 1 : row_pos;
    if (in_row == 0) return 1'b0;
    res.pix = smoothed;
    return 1'b1;
  endfunction

  // scoreboard: outputs are checked before this edge's request is predicted
  always @(posedge clk) begin
    smoothed_t want;
    smoothed_t got;
    req_note_t note;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        if (expected_smoothed.size() == 0) begin
          $error("unexpected output pixel_out=%h frame_end=%b", m_tdata, m_tlast);
          fail_count++;
        end else begin
          want = expected_smoothed.pop_front();
          if (m_tdata !== want.pix) begin
            $error("pixel_out expected %h got %h", want.pix, m_tdata);
            fail_count++;
          end
          if (m_tlast !== want.last) begin
            $error("frame_end expected %b got %b", want.last, m_tlast);
            fail_count++;
          end
        end
      end
      if (s_tvalid && s_tready) begin
        note = sent_notes.pop_front();
        if (stencil_step(s_tdata, s_tuser, got) && !note.typed)
          expected_smoothed.push_back(got);
        if (note.typed && note.has_res) begin
          want.pix  = note.pix;
          want.last = note.last;
          expected_smoothed.push_back(want);
        end
      end
    end
  end

  // receiver: random stalls, calm stretches, and the long hold on request
  int stall_left = 0;
  int mode_left  = 0;
  int hold_seen  = 0;
  bit sink_calm  = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        sink_calm <= ($urandom_range(0, 2) == 0);
        mode_left <= $urandom_range(50, 300);
      end else begin
        mode_left <= mode_left - 1;
      end
      if (hold_seen != hold_asked) begin
        hold_seen  <= hold_asked;
        stall_left <= LONG_HOLD;
        m_tready   <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        m_tready   <= 1'b0;
      end else if (!sink_calm && $urandom_range(0, 4) == 0) begin
        stall_left <= pick_gap(fast_phase);
        m_tready   <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("four_neighbor_average_stencil_core verification failed");
      $finish;
    end
  end

  // present one request and hold it until taken, then maybe go idle
  task automatic offer(input logic [fnas_pkg::PIX_W-1:0] pix, input bit fl,
                       input req_note_t note, input int gap);
    sent_notes.push_back(note);
    s_tvalid <= 1'b1;
    s_tdata  <= pix;
    s_tuser  <= fl;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and wait until every predicted pixel has come out
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (expected_smoothed.size() != 0);
    repeat (SETTLE_GAP) @(posedge clk);
  endtask

  task automatic write_reg(input fnas_pkg::cfg_reg_t idx, input int val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= fnas_pkg::CFG_W'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == fnas_pkg::REG_FRAME_WIDTH) begin
      width_reg   = fnas_pkg::WREG_W'(val);
      frame_w_eff = clamp_dim(int'(width_reg), fnas_pkg::MAX_WIDTH_DEF);
    end else begin
      height_reg  = fnas_pkg::HREG_W'(val);
      frame_h_eff = clamp_dim(int'(height_reg), 1 << fnas_pkg::HREG_W);
    end
    @(posedge clk);
  endtask

  task automatic configure(input int w, input int h);
    settle();
    write_reg(fnas_pkg::REG_FRAME_WIDTH, w);
    write_reg(fnas_pkg::REG_FRAME_HEIGHT, h);
  endtask

  // raster rows with random content, now and then a stray flush
  task automatic send_rows(input int r0, input int r1);
    req_note_t note;
    note = '0;
    for (int r = r0; r < r1; r++) begin
      src_calm = ($urandom_range(0, 3) == 0);
      for (int c = 0; c < frame_w_eff; c++) begin
        if (!src_calm && $urandom_range(0, 24) == 0)
          offer(rand_pixel(), 1'b1, note, pick_gap(fast_phase));
        offer(rand_pixel(), 1'b0, note, src_calm ? 0 : pick_gap(fast_phase));
        items_sent++;
      end
    end
  endtask

  // push out the last row, mostly with flush requests
  task automatic send_drain();
    req_note_t note;
    note = '0;
    for (int c = 0; c < frame_w_eff; c++) begin
      offer(rand_pixel(), ($urandom_range(0, 4) != 0), note, pick_gap(fast_phase));
      items_sent++;
    end
  endtask

  task automatic send_frame();
    send_rows(0, frame_h_eff);
    send_drain();
  endtask

  initial begin
    req_note_t note;
    int        frames;
    int        wv;
    int        hv;
    int        wait_cycles;
    foreach (line_above[i]) begin
      line_above[i]     = '0;
      line_two_above[i] = '0;
    end
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed frames, expectations typed in
    configure(3, 3);
    foreach (DIRECTED_ROWS[i]) begin
      note.typed   = 1'b1;
      note.has_res = DIRECTED_ROWS[i].has_res;
      note.pix     = DIRECTED_ROWS[i].exp_pix;
      note.last    = DIRECTED_ROWS[i].exp_last;
      offer(DIRECTED_ROWS[i].pix, DIRECTED_ROWS[i].flush, note, pick_gap(1'b0));
    end

    // register values below the usable range clamp to 3, then a 4x3 frame
    configure(0, 0);
    repeat (2) send_frame();
    configure(1, 1);
    send_frame();
    configure(2, 2);
    send_frame();
    configure(4, 3);
    send_frame();

    // height raised mid-frame, with the receiver holding off for a while
    configure(5, 4);
    hold_asked <= hold_asked + 1;
    send_rows(0, 2);
    settle();
    write_reg(fnas_pkg::REG_FRAME_HEIGHT, 7);
    send_rows(2, 7);
    send_drain();

    // height dropped below the current row: drain starts right away
    configure(6, 9);
    send_rows(0, 5);
    settle();
    write_reg(fnas_pkg::REG_FRAME_HEIGHT, 3);
    send_drain();

    // random small frames
    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      case ($urandom_range(0, 9))
        0: wv = $urandom_range(0, 2);
        1: wv = $urandom_range(13, 24);
        default: wv = $urandom_range(3, 12);
      endcase
      case ($urandom_range(0, 9))
        0: hv = $urandom_range(0, 2);
        1: hv = $urandom_range(7, 12);
        default: hv = $urandom_range(3, 6);
      endcase
      configure(wv, hv);
      frames = $urandom_range(1, 3);
      repeat (frames) begin
        if (items_sent < RANDOM_ITEMS) send_frame();
      end
    end

    // tallest height register value: a few rows under a long hold, then the
    // height drops below the current row so the drain starts
    fast_phase = 1'b1;
    configure(3, 8191);
    hold_asked <= hold_asked + 1;
    send_rows(0, 4);
    settle();
    write_reg(fnas_pkg::REG_FRAME_HEIGHT, 3);
    send_drain();

    s_tvalid <= 1'b0;
    for (wait_cycles = 0; wait_cycles < 5000 && expected_smoothed.size() != 0; wait_cycles++)
      @(posedge clk);
    if (expected_smoothed.size() != 0) begin
      $error("%0d expected pixels never came out", expected_smoothed.size());
      fail_count++;
    end
    repeat (16) @(posedge clk);
    if (fail_count == 0) begin
      $display("four_neighbor_average_stencil_core verification clean");
    end else begin
      $display("four_neighbor_average_stencil_core verification failed");
    end
    $finish;
  end

endmodule
